[rtl/ipv4f_pkg.sv]
// ipv4f_pkg: types and constants shared by the ipv4 text address finder
// scan state layout, phase codes and character codes
// no dependencies
`default_nettype none

package ipv4f_pkg;

    // scan phase
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SCAN   = 2'd1,
        PH_FOURTH = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // per-string scan state
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  dot_count;
        logic [2:0]  digit_count;
        logic [9:0]  octet_value;
        logic        address_seen;
    } t_scan_state;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [9:0] OCTET_LIMIT = 10'd256;
    localparam logic [2:0] MAX_DIGITS  = 3'd3;
    localparam logic [2:0] OVER_DIGITS = 3'd4;
    localparam logic [1:0] LAST_DOT    = 2'd2;

    localparam t_scan_state SCAN_RESET = '{
        phase:        PH_SKIP,
        dot_count:    2'd0,
        digit_count:  3'd0,
        octet_value:  10'd0,
        address_seen: 1'b0
    };

    // octet run holds 1 to 3 digits and a value below 256
    function automatic logic run_good(input logic [2:0] dig, input logic [9:0] val);
        run_good = (dig != 3'd0) && (dig <= MAX_DIGITS) && (val < OCTET_LIMIT);
    endfunction

endpackage

`default_nettype wire

[rtl/ipv4f_step.sv]
// ipv4f_step: next scan state for one text byte, and the answer on the last byte
// pure combinational logic
// depends on ipv4f_pkg
`default_nettype none

module ipv4f_step
    import ipv4f_pkg::*;
(
    input  wire t_scan_state i_state,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output t_scan_state      o_state,
    output logic             o_found
);

    always_comb begin
        t_phase     ph;
        logic [1:0] dc;
        logic [2:0] dg;
        logic [9:0] ov;
        logic       seen;
        logic       used;
        logic       is_digit;
        logic       visible;
        logic [9:0] dval;

        ph       = i_state.phase;
        dc       = i_state.dot_count;
        dg       = i_state.digit_count;
        ov       = i_state.octet_value;
        seen     = i_state.address_seen;
        used     = 1'b0;
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        visible  = !i_byte[7] && (i_byte > CH_SPACE);
        dval     = {6'd0, i_byte[3:0]};

        if (ph != PH_DONE) begin
            // fourth octet digits, judged on the first non-digit
            if (ph == PH_FOURTH) begin
                if (is_digit) begin
                    used = 1'b1;
                    if (dg < MAX_DIGITS) begin
                        ov = (ov << 3) + (ov << 1) + dval;
                        dg = dg + 3'd1;
                    end else begin
                        dg = OVER_DIGITS;
                    end
                end else begin
                    seen = run_good(dg, ov);
                    ph   = PH_SCAN;
                    dc   = 2'd0;
                    dg   = 3'd0;
                    ov   = 10'd0;
                end
            end

            if (!used) begin
                if (i_byte == CH_NUL) begin
                    ph = PH_DONE;
                end else if (!(ph == PH_SKIP && i_byte == CH_SPACE)) begin
                    if (ph == PH_SKIP) begin
                        ph = PH_SCAN;
                    end
                    // scanning
                    if (seen && visible) begin
                        seen = 1'b0;
                        ph   = PH_DONE;
                    end else if (is_digit) begin
                        if (dg < MAX_DIGITS) begin
                            ov = (ov << 3) + (ov << 1) + dval;
                            dg = dg + 3'd1;
                        end else begin
                            dg = OVER_DIGITS;
                        end
                    end else if (i_byte == CH_DOT) begin
                        if (!run_good(dg, ov)) begin
                            seen = 1'b0;
                            ph   = PH_DONE;
                        end else begin
                            dg = 3'd0;
                            ov = 10'd0;
                            if (dc == LAST_DOT) begin
                                dc = 2'd0;
                                ph = PH_FOURTH;
                            end else begin
                                dc = dc + 2'd1;
                            end
                        end
                    end else begin
                        dc = 2'd0;
                        dg = 3'd0;
                        ov = 10'd0;
                    end
                end
            end
        end

        // end of string: judge a fourth octet in progress, then clear
        if (ph == PH_FOURTH) begin
            o_found = run_good(dg, ov);
        end else begin
            o_found = seen;
        end

        if (i_last) begin
            o_state = SCAN_RESET;
        end else begin
            o_state.phase        = ph;
            o_state.dot_count    = dc;
            o_state.digit_count  = dg;
            o_state.octet_value  = ov;
            o_state.address_seen = seen;
        end
    end

endmodule

`default_nettype wire

[rtl/ipv4f_out.sv]
// ipv4f_out: result register on the master side of the stream
// holds one answer until it is taken
// depends on ipv4f_pkg
`default_nettype none

module ipv4f_out
    import ipv4f_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire logic i_found,
    input  wire logic i_m_tready,
    output logic      o_m_tvalid,
    output logic      o_found,
    output logic      o_can_load
);

    logic r_valid;
    logic n_valid;
    logic r_found;

    // valid flag: set on load, cleared when the transfer completes
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // answer payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_found <= i_found;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_found    = r_found;
    assign o_can_load = !r_valid || i_m_tready;

endmodule

`default_nettype wire

[rtl/ipv4_text_address_finder_top.sv]
// ipv4_text_address_finder_top: scans a byte stream for a dotted-decimal address
// one text byte per transfer, one answer per string on the last byte
// depends on ipv4f_pkg, ipv4f_step, ipv4f_out
// the answer is registered and valid in the cycle after the transfer of the last byte
// one byte per cycle while the input is ready, with the scan state registered on each transfer;
// the input stalls only while an answer waits and the output side holds off
// reset (synchronous, active low) returns the scan state to leading space skip
// and drops the output valid
`default_nettype none

module ipv4_text_address_finder_top
    import ipv4f_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  wire logic       i_s_tlast,   // end_of_text
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [0] address_found, [7:1] zero
);

    t_scan_state r_state;
    t_scan_state n_state;
    logic        step_found;
    logic        can_load;
    logic        in_xfer;
    logic        out_found;

    assign o_s_tready = can_load;
    assign in_xfer    = i_s_tvalid && can_load;

    ipv4f_step u_step (
        .i_state (r_state),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_state (n_state),
        .o_found (step_found)
    );

    // scan state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    ipv4f_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer && i_s_tlast),
        .i_found    (step_found),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_found    (out_found),
        .o_can_load (can_load)
    );

    assign o_m_tdata = {7'd0, out_found};

    // the last byte of a string always leaves an answer waiting
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_s_tlast) |=> o_m_tvalid)
        else $error("no answer after last byte");

    // the scan state is back at reset after the last byte
    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_s_tlast) |=> (r_state == SCAN_RESET))
        else $error("scan state not cleared after last byte");

    // a new answer only comes from a last byte
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(in_xfer && i_s_tlast))
        else $error("answer without last byte");

    // a decided string stays decided until its last byte
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DONE && !(in_xfer && i_s_tlast)) |=>
        (r_state.phase == PH_DONE))
        else $error("decided phase left early");

endmodule

`default_nettype wire

[dv/ipv4_text_address_finder_checker.sv]
`timescale 1ns / 1ps
// ipv4_text_address_finder_checker: watches both stream channels of the address finder,
// predicts the answer of each string and compares every answer transfer
// depends on ipv4f_pkg for the scan state type, phase codes and character codes

module ipv4_text_address_finder_checker
    import ipv4f_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  wire logic       i_s_tlast,   // end_of_text
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [0] address_found, [7:1] zero
    output int              o_fail_count,
    output int              o_pending,
    output int              o_answers,
    output int              o_found
);

    // scan state of the string in flight and answers still owed by the block
    t_scan_state scan_st;
    bit          expected_found[$];
    int          mismatches;
    int          answers_seen;
    int          found_seen;

    assign o_fail_count = mismatches;
    assign o_answers    = answers_seen;
    assign o_found      = found_seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    endtask

    // an octet is 1 to 3 digits with a value below 256
    function automatic bit octet_fits(input logic [2:0] digits, input logic [9:0] value);
        return (digits != 3'd0) && (digits <= MAX_DIGITS) && (value < OCTET_LIMIT);
    endfunction

    task automatic clear_octet();
        scan_st.digit_count = 3'd0;
        scan_st.octet_value = 10'd0;
    endtask

    // digits beyond the third only mark the run as too long
    task automatic take_octet_digit(input logic [7:0] ch);
        if (scan_st.digit_count < MAX_DIGITS) begin
            scan_st.octet_value = scan_st.octet_value * 10'd10 + 10'(ch - CH_ZERO);
            scan_st.digit_count = scan_st.digit_count + 3'd1;
        end else begin
            scan_st.digit_count = OVER_DIGITS;
        end
    endtask

    task automatic fail_text();
        scan_st.address_seen = 1'b0;
        scan_st.phase        = PH_DONE;
    endtask

    task automatic close_fourth_octet();
        scan_st.address_seen = octet_fits(scan_st.digit_count, scan_st.octet_value);
        scan_st.phase        = PH_SCAN;
        scan_st.dot_count    = 2'd0;
        clear_octet();
    endtask

    // one byte of the scanning phase
    task automatic scan_text_byte(input logic [7:0] ch);
        bit visible;
        visible = (ch > CH_SPACE) && (ch < 8'd128);
        if (scan_st.address_seen && visible) begin
            fail_text();
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            take_octet_digit(ch);
        end else if (ch == CH_DOT) begin
            if (!octet_fits(scan_st.digit_count, scan_st.octet_value)) begin
                fail_text();
            end else begin
                clear_octet();
                if (scan_st.dot_count == LAST_DOT) begin
                    scan_st.dot_count = 2'd0;
                    scan_st.phase     = PH_FOURTH;
                end else begin
                    scan_st.dot_count = scan_st.dot_count + 2'd1;
                end
            end
        end else begin
            scan_st.dot_count = 2'd0;
            clear_octet();
        end
    endtask

    // advance the scan by one accepted byte, queue the answer on the last one
    task automatic track_text_byte(input logic [7:0] ch, input logic last);
        bit consumed;
        consumed = 1'b0;
        if (scan_st.phase != PH_DONE) begin
            if (scan_st.phase == PH_FOURTH) begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    take_octet_digit(ch);
                    consumed = 1'b1;
                end else begin
                    close_fourth_octet();
                end
            end
            if (!consumed) begin
                if (ch == CH_NUL) begin
                    scan_st.phase = PH_DONE;
                end else if (!(scan_st.phase == PH_SKIP && ch == CH_SPACE)) begin
                    if (scan_st.phase == PH_SKIP) begin
                        scan_st.phase = PH_SCAN;
                    end
                    scan_text_byte(ch);
                end
            end
        end
        if (last) begin
            if (scan_st.phase == PH_FOURTH) begin
                close_fourth_octet();
            end
            expected_found.push_back(scan_st.address_seen);
            scan_st = SCAN_RESET;
        end
    endtask

    // answers are checked before the byte of the same edge is taken in
    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            scan_st = SCAN_RESET;
            expected_found.delete();
            mismatches   = 0;
            answers_seen = 0;
            found_seen   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                answers_seen++;
                if (i_m_tdata[0]) begin
                    found_seen++;
                end
                if (expected_found.size() == 0) begin
                    report_mismatch("answer with no string pending", i_m_tdata[0], 0);
                end else begin
                    want = expected_found.pop_front();
                    if (i_m_tdata[0] !== want) begin
                        report_mismatch("address_found", i_m_tdata[0], want);
                    end
                    if (i_m_tdata[7:1] !== 7'd0) begin
                        report_mismatch("tdata padding", i_m_tdata[7:1], 0);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                track_text_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending <= expected_found.size();
    end

endmodule

[dv/ipv4_text_address_finder_top_tb.sv]
`timescale 1ns / 1ps
// ipv4_text_address_finder_top_tb: drives text strings into the address finder
// with random stalls on both sides and gives the verdict from the checker
// depends on ipv4f_pkg, ipv4_text_address_finder_top, ipv4_text_address_finder_checker

module ipv4_text_address_finder_top_tb
    import ipv4f_pkg::*;
;

    localparam int ITEM_TARGET  = 600;
    localparam int CALM_ITEMS   = 80;
    localparam int QUIET_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] text_byte
    logic       i_s_tlast;   // end_of_text
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [0] address_found, [7:1] zero

    int         fail_count;
    int         pending;
    int         answers;
    int         found;
    int         bytes_sent;
    int         strings_sent;
    int         quiet_cycles;
    bit         stall_enable;
    logic [7:0] text_q[$];

    ipv4_text_address_finder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    ipv4_text_address_finder_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_answers    (answers),
        .o_found      (found)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // answer side: ready drops in random bursts while stalls are enabled
    initial begin
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (stall_enable && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    // one byte transfer, with an occasional gap before it
    task automatic send_byte(input logic [7:0] ch, input logic last);
        if (stall_enable && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
        strings_sent++;
    endtask

    // mostly address-shaped strings with random octets, the rest random noise
    task automatic make_random_text();
        int         ndig;
        bit         boundary;
        logic [7:0] ch;
        if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
            if ($urandom_range(0, 4) == 0) begin
                text_q.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0) begin
                    text_q.push_back(CH_SPACE);
                end
            end
            for (int o = 0; o < 4; o++) begin
                case ($urandom_range(0, 19))
                    0:       ndig = 0;
                    1:       ndig = 4;
                    default: ndig = $urandom_range(1, 3);
                endcase
                // bias three-digit octets toward the 250..259 boundary
                boundary = (ndig == 3) && ($urandom_range(0, 2) == 0);
                for (int k = 0; k < ndig; k++) begin
                    if (boundary && k == 0) begin
                        ch = "2";
                    end else if (boundary && k == 1) begin
                        ch = "5";
                    end else begin
                        ch = CH_ZERO + 8'($urandom_range(0, 9));
                    end
                    text_q.push_back(ch);
                end
                if (o < 3) begin
                    text_q.push_back(($urandom_range(0, 9) != 0) ? CH_DOT
                                                                : 8'($urandom_range(0, 255)));
                end
            end
            // tail: nothing, invisible bytes, a visible byte, or a terminator
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                4, 5, 6: begin
                    repeat ($urandom_range(1, 3)) begin
                        text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 32))
                                                              : 8'($urandom_range(128, 255)));
                    end
                end
                7, 8: text_q.push_back(8'($urandom_range(33, 127)));
                default: begin
                    text_q.push_back(CH_NUL);
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    4, 5:       text_q.push_back(CH_DOT);
                    6:          text_q.push_back(CH_SPACE);
                    default:    text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_s_tvalid   <= 1'b0;
        i_s_tdata    <= 8'd0;
        i_s_tlast    <= 1'b0;
        quiet_cycles <= 0;
        bytes_sent   = 0;
        strings_sent = 0;
        stall_enable = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leading space, boundary value 255, fourth octet closed by the last byte
        push_text(" 1.2.3.255");
        send_text();
        // invisible high byte after the address, then a visible byte fails it
        push_text("0.0.0.0");
        text_q.push_back(8'hff);
        push_text("!");
        send_text();
        // dot with no digits before it
        push_text(".");
        send_text();
        // empty fourth octet ended by a zero byte, later digit ignored
        push_text("1.1.1.");
        text_q.push_back(CH_NUL);
        push_text("9");
        send_text();

        // random strings, calm at the end
        while (bytes_sent < ITEM_TARGET) begin
            stall_enable = (bytes_sent < ITEM_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            make_random_text();
            send_text();
        end
        i_s_tvalid <= 1'b0;

        // wait for every answer, then keep watching for stray transfers
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d strings in %0d bytes with random stalls on both channels",
                 strings_sent, bytes_sent);
        $display("checked %0d answers, %0d of them with an address found", answers, found);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
